// ===== hw/rtl/drt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, register codes and the microcode ROM of the timer unit.
// ----------------------------------------------------------------------------
package drt_pkg;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register map
    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_CNT  = 2'd1;
    localparam logic [1:0] REG_MOD  = 2'd2;
    localparam logic [1:0] REG_CTRL = 2'd3;

    // control bits 1:0
    localparam logic [1:0] RATE_1024 = 2'd0;
    localparam logic [1:0] RATE_16   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_256  = 2'd3;

    localparam int unsigned CTRL_ENABLE_BIT = 2;
    localparam int unsigned PC_W            = 3;
    localparam int unsigned ACC_W           = 11;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] tick_cycles;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_BUS,
        OP_DIV,
        OP_STEP,
        OP_STORE,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_EMPTY,
        COND_IS_TICK,
        COND_TIMER_OFF,
        COND_DUE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic timer_off;
        logic due;
        logic out_busy;
    } status_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 3'd1;
    localparam logic [PC_W-1:0] PC_BUS      = 3'd2;
    localparam logic [PC_W-1:0] PC_DIV      = 3'd3;
    localparam logic [PC_W-1:0] PC_STEP     = 3'd4;
    localparam logic [PC_W-1:0] PC_STORE    = 3'd5;
    localparam logic [PC_W-1:0] PC_FINISH   = 3'd7;

    // taken jump goes to target, otherwise pc + 1 (FINISH wraps to IDLE)
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_IDLE:     w = '{OP_ACCEPT, COND_IN_EMPTY,  PC_IDLE};
            PC_DISPATCH: w = '{OP_NONE,   COND_IS_TICK,   PC_DIV};
            PC_BUS:      w = '{OP_BUS,    COND_ALWAYS,    PC_FINISH};
            PC_DIV:      w = '{OP_DIV,    COND_TIMER_OFF, PC_FINISH};
            PC_STEP:     w = '{OP_STEP,   COND_DUE,       PC_STEP};
            PC_STORE:    w = '{OP_STORE,  COND_ALWAYS,    PC_FINISH};
            PC_FINISH:   w = '{OP_FINISH, COND_OUT_BUSY,  PC_FINISH};
            default:     w = '{OP_NONE,   COND_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    // counter period selected by control bits 1:0
    function automatic logic [ACC_W-1:0] rate_of(input logic [1:0] code);
        logic [ACC_W-1:0] r;
        case (code)
            RATE_1024: r = ACC_W'(1024);
            RATE_16:   r = ACC_W'(16);
            RATE_64:   r = ACC_W'(64);
            default:   r = ACC_W'(256);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/drt_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module drt_sequencer
    import drt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ucode_t       uword
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign uword = ucode_rom(pc_reg);

    always_comb
    begin
        case (uword.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_IN_EMPTY:  taken = !status.in_valid;
            COND_IS_TICK:   taken = status.is_tick;
            COND_TIMER_OFF: taken = status.timer_off;
            COND_DUE:       taken = status.due;
            COND_OUT_BUSY:  taken = status.out_busy;
            default:        taken = 1'b1;
        endcase
        pc_next = taken ? uword.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/drt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_datapath
// Timer registers, accumulator and result register, driven by control words.
// ----------------------------------------------------------------------------
module drt_datapath
    import drt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire ucode_t uword,
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire req_t   req_data,
    output logic        rsp_valid,
    input  wire logic   rsp_ready,
    output rsp_t        rsp_data,
    output status_t     status
);

    // architectural state
    logic [7:0]       div_val_reg, div_val_next;
    logic [7:0]       div_res_reg, div_res_next;
    logic [7:0]       cnt_val_reg, cnt_val_next;
    logic [9:0]       cnt_res_reg, cnt_res_next;
    logic [7:0]       mod_reg,     mod_next;
    logic [7:0]       ctl_reg,     ctl_next;
    logic             rsp_valid_reg, rsp_valid_next;
    // working payload
    req_t             req_reg,  req_next;
    logic [ACC_W-1:0] cacc_reg, cacc_next;
    logic [7:0]       rd_reg,   rd_next;
    logic             irq_reg,  irq_next;
    rsp_t             rsp_reg,  rsp_next;

    logic [ACC_W-1:0] rate;
    logic [8:0]       div_sum;
    logic             due;
    logic             out_free;

    assign rate     = rate_of(ctl_reg[1:0]);
    assign due      = cacc_reg >= rate;
    assign div_sum  = {1'b0, div_res_reg} + {1'b0, req_reg.tick_cycles};
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign req_ready = uword.op == OP_ACCEPT;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign status.in_valid  = req_valid;
    assign status.is_tick   = req_reg.req_type == REQ_TICK;
    assign status.timer_off = !ctl_reg[CTRL_ENABLE_BIT];
    assign status.due       = due;
    assign status.out_busy  = !out_free;

    always_comb
    begin
        div_val_next   = div_val_reg;
        div_res_next   = div_res_reg;
        cnt_val_next   = cnt_val_reg;
        cnt_res_next   = cnt_res_reg;
        mod_next       = mod_reg;
        ctl_next       = ctl_reg;
        req_next       = req_reg;
        cacc_next      = cacc_reg;
        rd_next        = rd_reg;
        irq_next       = irq_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (uword.op)
            OP_ACCEPT:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    rd_next  = 8'd0;
                    irq_next = 1'b0;
                end
            end
            OP_BUS:
            begin
                if (req_reg.req_type == REQ_WRITE)
                begin
                    case (req_reg.reg_select)
                        REG_DIV: div_val_next = req_reg.write_data;
                        REG_CNT: cnt_val_next = req_reg.write_data;
                        REG_MOD: mod_next     = req_reg.write_data;
                        default: ctl_next     = req_reg.write_data;
                    endcase
                end
                else if (req_reg.req_type == REQ_READ)
                begin
                    case (req_reg.reg_select)
                        REG_DIV: rd_next = div_val_reg;
                        REG_CNT: rd_next = cnt_val_reg;
                        REG_MOD: rd_next = mod_reg;
                        default: rd_next = ctl_reg;
                    endcase
                end
            end
            OP_DIV:
            begin
                div_val_next = div_val_reg + {7'd0, div_sum[8]};
                div_res_next = div_sum[7:0];
                cacc_next    = {1'b0, cnt_res_reg} + {3'd0, req_reg.tick_cycles};
            end
            OP_STEP:
            begin
                if (due)
                begin
                    cacc_next = cacc_reg - rate;
                    if (cnt_val_reg == 8'hFF)
                    begin
                        cnt_val_next = mod_reg;   // overflow reload
                        irq_next     = 1'b1;
                    end
                    else
                    begin
                        cnt_val_next = cnt_val_reg + 8'd1;
                    end
                end
            end
            OP_STORE:
            begin
                cnt_res_next = cacc_reg[9:0];
            end
            OP_FINISH:
            begin
                if (out_free)
                begin
                    rsp_next       = '{read_data: rd_reg, timer_irq: irq_reg};
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_val_reg   <= 8'd0;
            div_res_reg   <= 8'd0;
            cnt_val_reg   <= 8'd0;
            cnt_res_reg   <= 10'd0;
            mod_reg       <= 8'd0;
            ctl_reg       <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            div_val_reg   <= div_val_next;
            div_res_reg   <= div_res_next;
            cnt_val_reg   <= cnt_val_next;
            cnt_res_reg   <= cnt_res_next;
            mod_reg       <= mod_next;
            ctl_reg       <= ctl_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        cacc_reg <= cacc_next;
        rd_reg   <= rd_next;
        irq_reg  <= irq_next;
        rsp_reg  <= rsp_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/divider_and_reloading_timer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_unit
// Divider / reloading counter timer with four byte registers.
//
// Requests arrive on req_valid/req_ready (req_data: kind, register, write
// byte, tick cycles); each request gives one response on rsp_valid/rsp_ready
// (read byte, overflow interrupt). A microcoded sequencer walks one request
// at a time: accept, dispatch, then either one bus step (read/write) or a
// divider step and, with the timer on, one counter increment per cycle and
// a residue store, then a finish step that loads the response register.
// An enabled tick makes N counter increments (N <= 16 for a tick_cycles
// value of 255 at the fastest rate, more only right after a rate change
// left a large residue); with the timer off it makes none.
// The next request can be accepted in the cycle after the response is
// loaded, so a response may wait in its register while the following
// request runs; a stalled receiver holds the sequencer only at the finish
// of that one.
// Reset clears all timer registers to zero and empties the response slot.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer_unit
    import drt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp_data
);

    ucode_t  uword;
    status_t status;

    drt_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    drt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .uword     (uword),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .status    (status)
    );

endmodule
`default_nettype wire
